// ----- sv/kwsi_pkg.sv -----
// ----------------------------------------------------------------------------
// kwsi_pkg
// Shared types, constants and exponential weight tables for the scattered
// point interpolator.
// ----------------------------------------------------------------------------
package kwsi_pkg;

  localparam int unsigned MAX_POINTS  = 4096;
  localparam int unsigned INT_STEPS   = 23;
  localparam int unsigned FRAC_STEPS  = 16;
  localparam int unsigned FRAC_STAGES = FRAC_STEPS;
  localparam int unsigned SQRT_STAGES = 32;
  localparam int unsigned DIV_STAGES  = 48;
  localparam int unsigned PIPE_LAT    = SQRT_STAGES + DIV_STAGES + FRAC_STAGES + 12;
  localparam int unsigned DRAIN_W     = $clog2(PIPE_LAT + 1);

  localparam logic [31:0] DEFAULT_HEIGHT     = 32'hFFFF_FA00;
  localparam logic [31:0] NEAR_RADIUS_RESET  = 32'hFFFF_FF00;
  localparam logic [30:0] FAR_RADIUS_RESET   = 31'd128000;
  localparam logic [30:0] DECAY_LENGTH_RESET = 31'd2560;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_NEAR     = 3'd0,
    ST_WEIGHTED = 3'd1,
    ST_DEFAULT  = 3'd2,
    ST_LOADED   = 3'd3,
    ST_FULL     = 3'd4,
    ST_CLEARED  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_NEAR  = 2'd0,
    CFG_FAR   = 2'd1,
    CFG_DECAY = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] point_height;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] interp_height;
    logic [2:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [31:0] near_radius;
    logic [30:0] far_radius;
    logic [30:0] decay_length;
  } cfg_t;

  typedef struct packed {
    logic    load_we;
    logic    scan_rd;
    logic    q_latch;
    logic    acc_clr;
    logic    div_start;
    logic    emit_fixed;
    status_e fixed_status;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

  typedef logic [INT_STEPS-1:0][32:0]  int_tab_t;
  typedef logic [FRAC_STEPS:1][31:0]   frac_tab_t;

  function automatic logic [63:0] exp_neg_pow2(int unsigned k);
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'd1 << 60;
    sum  = term;
    for (int unsigned n = 1; n < 30; n++) begin
      term = (term >> k) / 64'(n);
      if (n[0]) sum = sum - term;
      else sum = sum + term;
    end
    return (sum + (64'd1 << 27)) >> 28;
  endfunction

  function automatic int_tab_t build_int_tab();
    int_tab_t    t;
    logic [63:0] e1;
    logic [63:0] w;
    e1   = exp_neg_pow2(0);
    w    = 64'd1 << 32;
    t[0] = w[32:0];
    for (int unsigned n = 1; n < INT_STEPS; n++) begin
      w    = (w * e1 + (64'd1 << 31)) >> 32;
      t[n] = w[32:0];
    end
    return t;
  endfunction

  function automatic frac_tab_t build_frac_tab();
    frac_tab_t   t;
    logic [63:0] e;
    for (int unsigned k = 1; k <= FRAC_STEPS; k++) begin
      e    = exp_neg_pow2(k);
      t[k] = e[31:0];
    end
    return t;
  endfunction

  localparam int_tab_t  INT_TAB  = build_int_tab();
  localparam frac_tab_t FRAC_TAB = build_frac_tab();

endpackage

// ----- sv/kwsi_ram.sv -----
// ----------------------------------------------------------------------------
// kwsi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kwsi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/kwsi_div.sv -----
// ----------------------------------------------------------------------------
// kwsi_div
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module kwsi_div #(
  parameter int unsigned NumW = 78,
  parameter int unsigned DenW = 45
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [31:0]     quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] mag_q, mag_d;
  logic [DenW-1:0] rem_q, rem_d, den_q, den_d;
  logic [31:0]     quo_q, quo_d;
  logic [DenW:0]   rem_sh;
  logic            qb;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    rem_sh = {rem_q, mag_q[NumW-1]};
    qb     = rem_sh >= {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = num_i[NumW-1];
      mag_d  = num_i[NumW-1] ? (~num_i + NumW'(1)) : num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = '0;
    end else if (busy_q) begin
      rem_d = qb ? DenW'(rem_sh - {1'b0, den_q}) : rem_sh[DenW-1:0];
      mag_d = {mag_q[NumW-2:0], qb};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        quo_d  = neg_q ? (~mag_d[31:0] + 32'd1) : mag_d[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    cnt_q <= cnt_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- sv/kwsi_ctrl.sv -----
// ----------------------------------------------------------------------------
// kwsi_ctrl
// Sequencer: load and clear items, point scan, pipeline drain and final divide.
// ----------------------------------------------------------------------------
module kwsi_ctrl import kwsi_pkg::*; #(
  parameter int unsigned MaxPoints = MAX_POINTS,
  localparam int unsigned CntW  = $clog2(MaxPoints + 1),
  localparam int unsigned AddrW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       kind_i,
  input  sts_t             sts_i,
  output logic             busy_o,
  output cmd_t             cmd_o,
  output logic [AddrW-1:0] addr_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DIV   = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    count_q, count_d, idx_q, idx_d;
  logic [DRAIN_W-1:0] drain_q, drain_d;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    drain_d = drain_q;
    cmd_o   = '{default: '0, fixed_status: ST_LOADED};
    addr_o  = (state_q == S_IDLE) ? count_q[AddrW-1:0] : idx_q[AddrW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (kind_e'(kind_i))
            KIND_LOAD: begin
              cmd_o.emit_fixed = 1'b1;
              if (count_q < CntW'(MaxPoints)) begin
                cmd_o.load_we = 1'b1;
                count_d       = count_q + CntW'(1);
              end else begin
                cmd_o.fixed_status = ST_FULL;
              end
            end
            KIND_QUERY: begin
              cmd_o.q_latch = 1'b1;
              cmd_o.acc_clr = 1'b1;
              idx_d         = '0;
              state_d       = S_SCAN;
            end
            KIND_CLEAR: begin
              count_d            = '0;
              cmd_o.emit_fixed   = 1'b1;
              cmd_o.fixed_status = ST_CLEARED;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (idx_q < count_q) begin
          cmd_o.scan_rd = 1'b1;
          idx_d         = idx_q + CntW'(1);
        end else begin
          drain_d = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        drain_d = drain_q + DRAIN_W'(1);
        if (drain_q == DRAIN_W'(PIPE_LAT - 1)) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      drain_q <= drain_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- sv/kwsi_datapath.sv -----
// ----------------------------------------------------------------------------
// kwsi_datapath
// Point store, distance / square root / weight pipeline, accumulators and
// result register.
// ----------------------------------------------------------------------------
module kwsi_datapath import kwsi_pkg::*; #(
  parameter int unsigned MaxPoints = MAX_POINTS,
  localparam int unsigned CntW  = $clog2(MaxPoints + 1),
  localparam int unsigned AddrW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic [AddrW-1:0] addr_i,
  input  in_item_t         item_i,
  input  cfg_t             cfg_i,
  output sts_t             sts_o,
  output logic             res_valid_o,
  output out_item_t        res_o
);

  localparam int unsigned AccW  = 65 + CntW;
  localparam int unsigned NearW = 32 + CntW;
  localparam int unsigned WsumW = 32 + CntW;

  typedef struct packed {
    logic        vld;
    logic [30:0] ax;
    logic [30:0] ay;
    logic [31:0] h;
  } ab_t;

  typedef struct packed {
    logic        vld;
    logic [61:0] ax2;
    logic [61:0] ay2;
    logic [31:0] h;
  } sq2_t;

  typedef struct packed {
    logic        vld;
    logic [62:0] v;
    logic [63:0] res;
    logic [31:0] h;
  } rt_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] r;
    logic [31:0] rem;
    logic [47:0] q;
    logic [31:0] h;
  } dv_t;

  typedef struct packed {
    logic        vld;
    logic        big;
    logic [15:0] frac;
    logic [32:0] w;
    logic [31:0] h;
  } ex_t;

  logic [31:0] qx_q, qy_q;
  logic [95:0] ram_rd;
  logic        rd_vld_q;
  ab_t         ab_q;
  sq2_t        sq2_q;
  rt_t         rt_q [SQRT_STAGES+1];
  dv_t         dv_q [DIV_STAGES+1];
  ex_t         ex_q [FRAC_STAGES+1];
  logic        mp_vld_q;
  logic [64:0] mp_q;
  logic [31:0] mw_q;

  logic signed [NearW-1:0] near_sum_q;
  logic [CntW-1:0]         near_cnt_q;
  logic signed [AccW-1:0]  acc_q;
  logic [WsumW-1:0]        wsum_q;

  kwsi_ram #(
    .Width(96),
    .Depth(MaxPoints)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load_we),
    .waddr_i(addr_i),
    .wdata_i({item_i.x_coord, item_i.y_coord, item_i.point_height}),
    .re_i   (cmd_i.scan_rd),
    .raddr_i(addr_i),
    .rdata_o(ram_rd)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_latch) begin
      qx_q <= item_i.x_coord;
      qy_q <= item_i.y_coord;
    end
  end

  logic [32:0] dx, dy, adx, ady;
  logic [30:0] dec_eff;

  assign dec_eff = (cfg_i.decay_length == '0) ? 31'd1 : cfg_i.decay_length;

  always_comb begin
    dx  = {ram_rd[95], ram_rd[95:64]} - {qx_q[31], qx_q};
    dy  = {ram_rd[63], ram_rd[63:32]} - {qy_q[31], qy_q};
    adx = dx[32] ? (~dx + 33'd1) : dx;
    ady = dy[32] ? (~dy + 33'd1) : dy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      ab_q     <= '0;
      sq2_q    <= '0;
      rt_q[0]  <= '0;
    end else begin
      rd_vld_q  <= cmd_i.scan_rd;
      ab_q.vld  <= rd_vld_q && (adx[32:31] == 2'b00) && (ady[32:31] == 2'b00);
      ab_q.ax   <= adx[30:0];
      ab_q.ay   <= ady[30:0];
      ab_q.h    <= ram_rd[31:0];
      sq2_q.vld <= ab_q.vld;
      sq2_q.ax2 <= ab_q.ax * ab_q.ax;
      sq2_q.ay2 <= ab_q.ay * ab_q.ay;
      sq2_q.h   <= ab_q.h;
      rt_q[0].vld <= sq2_q.vld;
      rt_q[0].v   <= {1'b0, sq2_q.ax2} + {1'b0, sq2_q.ay2};
      rt_q[0].res <= '0;
      rt_q[0].h   <= sq2_q.h;
    end
  end

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * i);
    logic [63:0] trial;
    assign trial = rt_q[i].res + Bit;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_q[i+1] <= '0;
      end else begin
        rt_q[i+1].vld <= rt_q[i].vld;
        rt_q[i+1].h   <= rt_q[i].h;
        if ({1'b0, rt_q[i].v} >= trial) begin
          rt_q[i+1].v   <= 63'({1'b0, rt_q[i].v} - trial);
          rt_q[i+1].res <= (rt_q[i].res >> 1) + Bit;
        end else begin
          rt_q[i+1].v   <= rt_q[i].v;
          rt_q[i+1].res <= rt_q[i].res >> 1;
        end
      end
    end
  end

  logic [31:0] r_fin;
  logic        is_near, is_far;

  assign r_fin   = rt_q[SQRT_STAGES].res[31:0];
  assign is_near = rt_q[SQRT_STAGES].vld &&
                   ($signed({1'b0, r_fin}) < $signed({cfg_i.near_radius[31], cfg_i.near_radius}));
  assign is_far  = rt_q[SQRT_STAGES].vld && !is_near && (r_fin < {1'b0, cfg_i.far_radius});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= '0;
    end else begin
      dv_q[0].vld <= is_far;
      dv_q[0].r   <= r_fin;
      dv_q[0].rem <= '0;
      dv_q[0].q   <= '0;
      dv_q[0].h   <= rt_q[SQRT_STAGES].h;
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_wdiv
    logic        nbit;
    logic [31:0] rsh;
    logic        qb;
    if (j < 32) begin : g_rbit
      assign nbit = dv_q[j].r[31-j];
    end else begin : g_zbit
      assign nbit = 1'b0;
    end
    assign rsh = {dv_q[j].rem[30:0], nbit};
    assign qb  = rsh >= {1'b0, dec_eff};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= '0;
      end else begin
        dv_q[j+1].vld <= dv_q[j].vld;
        dv_q[j+1].r   <= dv_q[j].r;
        dv_q[j+1].h   <= dv_q[j].h;
        dv_q[j+1].rem <= qb ? (rsh - {1'b0, dec_eff}) : rsh;
        dv_q[j+1].q   <= {dv_q[j].q[46:0], qb};
      end
    end
  end

  logic [47:0] t_fin;
  logic        t_big;

  assign t_fin = dv_q[DIV_STAGES].q;
  assign t_big = t_fin[47:16] >= 32'(INT_STEPS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_q[0] <= '0;
    end else begin
      ex_q[0].vld  <= dv_q[DIV_STAGES].vld;
      ex_q[0].big  <= t_big;
      ex_q[0].frac <= t_fin[15:0];
      ex_q[0].w    <= t_big ? 33'd1 : INT_TAB[t_fin[20:16]];
      ex_q[0].h    <= dv_q[DIV_STAGES].h;
    end
  end

  for (genvar k = 1; k <= FRAC_STAGES; k++) begin : g_frac
    logic [64:0] prod;
    logic [64:0] rnd;
    assign prod = 65'(ex_q[k-1].w) * 65'(FRAC_TAB[k]);
    assign rnd  = prod + (65'd1 << 31);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ex_q[k] <= '0;
      end else begin
        ex_q[k].vld  <= ex_q[k-1].vld;
        ex_q[k].big  <= ex_q[k-1].big;
        ex_q[k].frac <= ex_q[k-1].frac;
        ex_q[k].h    <= ex_q[k-1].h;
        if (!ex_q[k-1].big && ex_q[k-1].frac[FRAC_STAGES-k]) ex_q[k].w <= rnd[64:32];
        else ex_q[k].w <= ex_q[k-1].w;
      end
    end
  end

  logic [32:0]        w_raw;
  logic [31:0]        w_cl;
  logic signed [64:0] prod_hw;

  assign w_raw   = ex_q[FRAC_STAGES].w;
  assign w_cl    = w_raw[32] ? 32'hFFFF_FFFF : ((w_raw[31:0] == '0) ? 32'd1 : w_raw[31:0]);
  assign prod_hw = $signed(ex_q[FRAC_STAGES].h) * $signed({1'b0, w_cl});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mp_vld_q <= 1'b0;
    end else begin
      mp_vld_q <= ex_q[FRAC_STAGES].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    mp_q <= prod_hw;
    mw_q <= w_cl;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      near_sum_q <= '0;
      near_cnt_q <= '0;
      acc_q      <= '0;
      wsum_q     <= '0;
    end else begin
      if (is_near) begin
        near_sum_q <= near_sum_q + {{(NearW-32){rt_q[SQRT_STAGES].h[31]}}, rt_q[SQRT_STAGES].h};
        near_cnt_q <= near_cnt_q + CntW'(1);
      end
      if (mp_vld_q) begin
        acc_q  <= acc_q + {{(AccW-65){mp_q[64]}}, mp_q};
        wsum_q <= wsum_q + WsumW'(mw_q);
      end
    end
  end

  logic [AccW-1:0]  div_num;
  logic [WsumW-1:0] div_den;
  logic             div_done;
  logic [31:0]      div_quo;
  logic             use_near;

  assign use_near = (near_cnt_q != '0);
  assign div_num  = use_near ? {{(AccW-NearW){near_sum_q[NearW-1]}}, near_sum_q} : acc_q;
  assign div_den  = use_near ? WsumW'(near_cnt_q) : wsum_q;

  kwsi_div #(
    .NumW(AccW),
    .DenW(WsumW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign sts_o.div_done = div_done;

  logic      res_vld_q;
  out_item_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= cmd_i.emit_fixed || div_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_fixed) begin
      res_q.interp_height <= '0;
      res_q.status        <= cmd_i.fixed_status;
    end else if (div_done) begin
      if (use_near) begin
        res_q.interp_height <= div_quo;
        res_q.status        <= ST_NEAR;
      end else if (wsum_q != '0) begin
        res_q.interp_height <= div_quo;
        res_q.status        <= ST_WEIGHTED;
      end else begin
        res_q.interp_height <= DEFAULT_HEIGHT;
        res_q.status        <= ST_DEFAULT;
      end
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

// ----- sv/kernel_weighted_scatter_interpolator.sv -----
// ----------------------------------------------------------------------------
// kernel_weighted_scatter_interpolator
// Scattered point store with exponential-kernel height interpolation.
//
// Items enter on start_i/item_i and are taken when start_i is high and busy_o
// is low. Load and clear items give their result on the next cycle. A query
// scans all stored points, one per cycle, through the distance, square root,
// weight division and exponential pipeline, waits for that pipeline to drain,
// then runs one signed divide of one bit per cycle; the next item can be taken
// in the result cycle. The point scan, set by the single store read port,
// dominates the time of a query for a large store.
// Each result shows on result_o for one cycle with result_valid_o high; it is
// never held off. Configuration writes on cfg_we_i take effect at once; the
// user must make them only while the block is idle, as the block itself does
// not enforce this. Reset empties the store (its contents stay undefined) and
// loads the register defaults. Kind 3 is taken and dropped.
// ----------------------------------------------------------------------------
module kernel_weighted_scatter_interpolator import kwsi_pkg::*; #(
  parameter int unsigned MaxPoints = MAX_POINTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  in_item_t    item_i,
  output logic        busy_o,
  output logic        result_valid_o,
  output out_item_t   result_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned AddrW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;

  cfg_t             cfg_q;
  cmd_t             cmd;
  sts_t             sts;
  logic [AddrW-1:0] addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_radius  <= NEAR_RADIUS_RESET;
      cfg_q.far_radius   <= FAR_RADIUS_RESET;
      cfg_q.decay_length <= DECAY_LENGTH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_NEAR:  cfg_q.near_radius  <= cfg_data_i;
        CFG_FAR:   cfg_q.far_radius   <= cfg_data_i[30:0];
        CFG_DECAY: cfg_q.decay_length <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  kwsi_ctrl #(
    .MaxPoints(MaxPoints)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .kind_i (item_i.kind),
    .sts_i  (sts),
    .busy_o (busy_o),
    .cmd_o  (cmd),
    .addr_o (addr)
  );

  kwsi_datapath #(
    .MaxPoints(MaxPoints)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .addr_i     (addr),
    .item_i     (item_i),
    .cfg_i      (cfg_q),
    .sts_o      (sts),
    .res_valid_o(result_valid_o),
    .res_o      (result_o)
  );

  a_fixed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.status == ST_LOADED || result_o.status == ST_FULL ||
                       result_o.status == ST_CLEARED) |-> result_o.interp_height == '0)
    else $error("non-query result carries a nonzero height");

  a_busy_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && item_i.kind == KIND_QUERY))
    else $error("busy raised without an accepted query");

  a_query_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.status == ST_NEAR || result_o.status == ST_WEIGHTED ||
                       result_o.status == ST_DEFAULT) |-> $past(busy_o))
    else $error("query result outside a query");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !cmd.load_we && !cmd.emit_fixed)
    else $error("store written or fixed result emitted during a query");

endmodule
